### src/gfb_pkg.sv
`default_nettype none
package gfb_pkg;

   localparam int CHAN_W = 8;
   localparam int ADDR_IN_W = 19;
   localparam int PHASE_W = 4;
   localparam int SLOT_W = 2;
   localparam int STORE_COUNT = 3;

   localparam int FRAME_PIXELS_DEFAULT = 524288;
   localparam int MID_DEPTH_DEFAULT = 4;
   localparam int OUT_DEPTH_DEFAULT = 4;

   localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd12;
   localparam logic [PHASE_W-1:0] PHASE_CAPTURE_ONE = 4'd0;
   localparam logic [PHASE_W-1:0] PHASE_CAPTURE_TWO = 4'd2;
   localparam logic [PHASE_W-1:0] PHASE_CAPTURE_THREE = 4'd6;

   localparam logic [SLOT_W-1:0] SLOT_ONE = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_TWO = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_THREE = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_NONE = 2'd3;

   localparam logic [3:0] ROUND_HALF = 4'd8;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type pix;
      logic [STORE_COUNT-1:0] store_we;
   } front_word_type;

   function automatic logic [CHAN_W-1:0] blend_channel(
      input logic [CHAN_W-1:0] cur,
      input logic [CHAN_W-1:0] s1,
      input logic [CHAN_W-1:0] s2,
      input logic [CHAN_W-1:0] s3
   );
      logic [CHAN_W+3:0] v;
      logic [CHAN_W-1:0] q;
      logic [3:0] r;
      v = ({4'd0, cur} << 3) + {4'd0, cur} + {4'd0, s1} + ({4'd0, s2} << 1)
         + ({4'd0, s3} << 2);
      q = v[CHAN_W+3:4];
      r = v[3:0];
      if ((r > ROUND_HALF) || ((r == ROUND_HALF) && q[0])) begin
         q = CHAN_W'(q + 1'b1);
      end
      return q;
   endfunction

endpackage
`default_nettype wire

### src/gfb_fifo.sv
`default_nettype none
module gfb_fifo #(
   parameter int DEPTH = gfb_pkg::MID_DEPTH_DEFAULT,
   parameter int WIDTH = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [WIDTH-1:0]               wr_data,
   input  wire logic                           pop,
   output logic [WIDTH-1:0]                    rd_data,
   output logic                                full,
   output logic                                empty,
   output logic [$clog2(DEPTH+1)-1:0]          count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = slot_ff[rd_ptr_ff];
   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign count = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("Queue written while full.");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("Queue read while empty.");

endmodule
`default_nettype wire

### src/gfb_front.sv
`default_nettype none
module gfb_front #(
   parameter int FRAME_PIXELS = gfb_pkg::FRAME_PIXELS_DEFAULT,
   parameter int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_push,
   input  wire gfb_pkg::pixel_type                in_pix,
   input  wire logic [gfb_pkg::ADDR_IN_W-1:0]     in_addr,
   input  wire logic                              in_start,
   output logic                                   in_full,
   input  wire logic                              mid_full,
   output logic                                   mid_push,
   output gfb_pkg::front_word_type                mid_word,
   output logic [AW-1:0]                          mid_index
);

   localparam int AIW = gfb_pkg::ADDR_IN_W;
   localparam int RECIP_W = AIW + 1;
   localparam int RECIP = (1 << AIW) / FRAME_PIXELS;
   localparam int FP_W = $clog2(FRAME_PIXELS + 1);
   localparam int CMP_W = (FP_W > AIW) ? FP_W : AIW;
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
   localparam logic [FP_W-1:0] FP_V = FP_W'(FRAME_PIXELS);
   localparam logic [CMP_W-1:0] FP_CMP = CMP_W'(FRAME_PIXELS);

   logic go;
   logic accept;

   logic [gfb_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic filled_ff, filled_in;
   logic [gfb_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic fill_all_ff, fill_all_in;
   logic all_stores;
   logic [gfb_pkg::STORE_COUNT-1:0] we_now;

   logic f1_valid_ff, f2_valid_ff, f3_valid_ff;
   gfb_pkg::front_word_type f1_word_ff, f2_word_ff, f3_word_ff;
   logic [AIW-1:0] f1_addr_ff, f2_addr_ff;
   logic [AIW+RECIP_W-1:0] f1_prod_ff;
   logic [AIW+FP_W-1:0] f2_prod_in, f2_prod_ff;
   logic [AIW-1:0] diff;
   logic [CMP_W-1:0] resid;
   logic [AW-1:0] f3_index_ff;

   assign go = !(f3_valid_ff && mid_full);
   assign in_full = !go;
   assign accept = in_push && go;

   always_comb begin
      phase_in = phase_ff;
      filled_in = filled_ff;
      slot_in = slot_ff;
      fill_all_in = fill_all_ff;
      if (in_start) begin
         fill_all_in = !filled_ff;
         filled_in = 1'b1;
         if (phase_ff == gfb_pkg::PHASE_CAPTURE_ONE) begin
            slot_in = gfb_pkg::SLOT_ONE;
         end else if (phase_ff == gfb_pkg::PHASE_CAPTURE_TWO) begin
            slot_in = gfb_pkg::SLOT_TWO;
         end else if (phase_ff == gfb_pkg::PHASE_CAPTURE_THREE) begin
            slot_in = gfb_pkg::SLOT_THREE;
         end else begin
            slot_in = gfb_pkg::SLOT_NONE;
         end
         phase_in = (phase_ff >= gfb_pkg::PHASE_LAST) ? '0
            : gfb_pkg::PHASE_W'(phase_ff + 1'b1);
      end
      all_stores = fill_all_in || !filled_in;
      we_now[0] = all_stores || (slot_in == gfb_pkg::SLOT_ONE);
      we_now[1] = all_stores || (slot_in == gfb_pkg::SLOT_TWO);
      we_now[2] = all_stores || (slot_in == gfb_pkg::SLOT_THREE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         filled_ff <= 1'b0;
         slot_ff <= gfb_pkg::SLOT_NONE;
         fill_all_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         filled_ff <= filled_in;
         slot_ff <= slot_in;
         fill_all_ff <= fill_all_in;
      end
   end

   // The address is reduced modulo the frame size by a reciprocal estimate
   // that is at most one short, followed by a single correction.
   assign f2_prod_in = f1_prod_ff[AIW +: AIW] * FP_V;
   assign diff = AIW'({{FP_W{1'b0}}, f2_addr_ff} - f2_prod_ff);

   always_comb begin
      resid = CMP_W'(diff);
      if (resid >= FP_CMP) begin
         resid = CMP_W'(resid - FP_CMP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (go) begin
         f1_valid_ff <= accept;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         f1_word_ff.pix <= in_pix;
         f1_word_ff.store_we <= we_now;
         f1_addr_ff <= in_addr;
         f1_prod_ff <= in_addr * RECIP_V;
         f2_word_ff <= f1_word_ff;
         f2_addr_ff <= f1_addr_ff;
         f2_prod_ff <= f2_prod_in;
         f3_word_ff <= f2_word_ff;
         f3_index_ff <= resid[AW-1:0];
      end
   end

   assign mid_push = f3_valid_ff && go;
   assign mid_word = f3_word_ff;
   assign mid_index = f3_index_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= gfb_pkg::PHASE_LAST)
      else $error("Frame phase left its range.");
   a_unfilled_idle: assert property (@(posedge clock) disable iff (reset)
      !filled_ff |-> ((slot_ff == gfb_pkg::SLOT_NONE) && !fill_all_ff))
      else $error("Capture selected before the first frame start.");

endmodule
`default_nettype wire

### src/gfb_back.sv
`default_nettype none
module gfb_back #(
   parameter int FRAME_PIXELS = gfb_pkg::FRAME_PIXELS_DEFAULT,
   parameter int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1,
   parameter int OUT_DEPTH = gfb_pkg::OUT_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              mid_empty,
   input  wire gfb_pkg::front_word_type           mid_word,
   input  wire logic [AW-1:0]                     mid_index,
   output logic                                   mid_pop,
   input  wire logic [$clog2(OUT_DEPTH+1)-1:0]    out_count,
   output logic                                   out_push,
   output gfb_pkg::pixel_type                     out_pix
);

   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   gfb_pkg::pixel_type store_one [FRAME_PIXELS];
   gfb_pkg::pixel_type store_two [FRAME_PIXELS];
   gfb_pkg::pixel_type store_three [FRAME_PIXELS];

   logic issue;
   logic [CNT_W:0] pending;
   logic b1_valid_ff;
   gfb_pkg::front_word_type b1_word_ff;
   gfb_pkg::pixel_type rd_one_ff, rd_two_ff, rd_three_ff;
   gfb_pkg::pixel_type s1, s2, s3;

   assign pending = {1'b0, out_count} + (CNT_W + 1)'(b1_valid_ff);
   assign issue = !mid_empty && (pending < (CNT_W + 1)'(OUT_DEPTH));
   assign mid_pop = issue;

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_one_ff <= store_one[mid_index];
         if (mid_word.store_we[0]) begin
            store_one[mid_index] <= mid_word.pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_two_ff <= store_two[mid_index];
         if (mid_word.store_we[1]) begin
            store_two[mid_index] <= mid_word.pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_three_ff <= store_three[mid_index];
         if (mid_word.store_we[2]) begin
            store_three[mid_index] <= mid_word.pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b1_word_ff <= mid_word;
      end
   end

   // The reads return the old entry, so a store written by this word
   // contributes the word's own pixel.
   assign s1 = b1_word_ff.store_we[0] ? b1_word_ff.pix : rd_one_ff;
   assign s2 = b1_word_ff.store_we[1] ? b1_word_ff.pix : rd_two_ff;
   assign s3 = b1_word_ff.store_we[2] ? b1_word_ff.pix : rd_three_ff;

   assign out_push = b1_valid_ff;
   assign out_pix.blue = gfb_pkg::blend_channel(b1_word_ff.pix.blue, s1.blue, s2.blue,
      s3.blue);
   assign out_pix.green = gfb_pkg::blend_channel(b1_word_ff.pix.green, s1.green, s2.green,
      s3.green);
   assign out_pix.red = gfb_pkg::blend_channel(b1_word_ff.pix.red, s1.red, s2.red, s3.red);

endmodule
`default_nettype wire

### src/ghost_frame_blend_unit.sv
`default_nettype none
// Throughput: one word per cycle unless a stall holds it, with a three-stage front pipeline
// and a pipelined store port. The front stalls only when the middle queue is full; the back
// when the result queue, counting the word held in its read stage, has no room left.
// Reset clears the frame phase, the capture selection and all queue control state, but not the
// ghost stores; the user must write every entry before it is read, unchecked by the block.
module ghost_frame_blend_unit #(
   parameter int FRAME_PIXELS = gfb_pkg::FRAME_PIXELS_DEFAULT,
   parameter int MID_DEPTH = gfb_pkg::MID_DEPTH_DEFAULT,
   parameter int OUT_DEPTH = gfb_pkg::OUT_DEPTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire logic [gfb_pkg::CHAN_W-1:0]            req_blue_in,
   input  wire logic [gfb_pkg::CHAN_W-1:0]            req_green_in,
   input  wire logic [gfb_pkg::CHAN_W-1:0]            req_red_in,
   input  wire logic [gfb_pkg::ADDR_IN_W-1:0]         req_pixel_address,
   input  wire logic                                  req_frame_start,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output logic [gfb_pkg::CHAN_W-1:0]                 rsp_blue_out,
   output logic [gfb_pkg::CHAN_W-1:0]                 rsp_green_out,
   output logic [gfb_pkg::CHAN_W-1:0]                 rsp_red_out
);

   localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
   localparam int WORD_W = $bits(gfb_pkg::front_word_type);
   localparam int MID_W = WORD_W + AW;
   localparam int PIX_W = $bits(gfb_pkg::pixel_type);
   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   gfb_pkg::pixel_type in_pix;
   logic mid_full, mid_push, mid_pop, mid_empty;
   gfb_pkg::front_word_type mid_word_wr, mid_word_rd;
   logic [AW-1:0] mid_index_wr, mid_index_rd;
   logic [MID_W-1:0] mid_rd_data;
   logic [MID_CNT_W-1:0] mid_count;
   logic out_push, out_full;
   gfb_pkg::pixel_type out_pix_wr;
   logic [PIX_W-1:0] out_rd_data;
   logic [OUT_CNT_W-1:0] out_count;
   gfb_pkg::pixel_type rsp_pix;

   assign in_pix.blue = req_blue_in;
   assign in_pix.green = req_green_in;
   assign in_pix.red = req_red_in;

   gfb_front #(
      .FRAME_PIXELS(FRAME_PIXELS),
      .AW(AW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_push(req_push),
      .in_pix(in_pix),
      .in_addr(req_pixel_address),
      .in_start(req_frame_start),
      .in_full(req_full),
      .mid_full(mid_full),
      .mid_push(mid_push),
      .mid_word(mid_word_wr),
      .mid_index(mid_index_wr)
   );

   gfb_fifo #(
      .DEPTH(MID_DEPTH),
      .WIDTH(MID_W)
   ) u_mid_queue (
      .clock(clock),
      .reset(reset),
      .push(mid_push),
      .wr_data({mid_word_wr, mid_index_wr}),
      .pop(mid_pop),
      .rd_data(mid_rd_data),
      .full(mid_full),
      .empty(mid_empty),
      .count(mid_count)
   );

   assign mid_word_rd = mid_rd_data[MID_W-1:AW];
   assign mid_index_rd = mid_rd_data[AW-1:0];

   gfb_back #(
      .FRAME_PIXELS(FRAME_PIXELS),
      .AW(AW),
      .OUT_DEPTH(OUT_DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .mid_empty(mid_empty),
      .mid_word(mid_word_rd),
      .mid_index(mid_index_rd),
      .mid_pop(mid_pop),
      .out_count(out_count),
      .out_push(out_push),
      .out_pix(out_pix_wr)
   );

   gfb_fifo #(
      .DEPTH(OUT_DEPTH),
      .WIDTH(PIX_W)
   ) u_out_queue (
      .clock(clock),
      .reset(reset),
      .push(out_push),
      .wr_data(out_pix_wr),
      .pop(rsp_pop && !rsp_empty),
      .rd_data(out_rd_data),
      .full(out_full),
      .empty(rsp_empty),
      .count(out_count)
   );

   assign rsp_pix = out_rd_data;
   assign rsp_blue_out = rsp_pix.blue;
   assign rsp_green_out = rsp_pix.green;
   assign rsp_red_out = rsp_pix.red;

   a_mid_count_range: assert property (@(posedge clock) disable iff (reset)
      mid_count <= MID_CNT_W'(MID_DEPTH))
      else $error("Middle queue count out of range.");
   a_out_never_full_on_push: assert property (@(posedge clock) disable iff (reset)
      out_full |-> !out_push)
      else $error("Result written while the result queue is full.");

endmodule
`default_nettype wire

### tb/ghost_frame_blend_checker.sv
module ghost_frame_blend_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   input  wire logic                          req_full,
   input  wire logic [gfb_pkg::CHAN_W-1:0]    req_blue_in,
   input  wire logic [gfb_pkg::CHAN_W-1:0]    req_green_in,
   input  wire logic [gfb_pkg::CHAN_W-1:0]    req_red_in,
   input  wire logic [gfb_pkg::ADDR_IN_W-1:0] req_pixel_address,
   input  wire logic                          req_frame_start,
   input  wire logic                          rsp_empty,
   input  wire logic                          rsp_pop,
   input  wire logic [gfb_pkg::CHAN_W-1:0]    rsp_blue_out,
   input  wire logic [gfb_pkg::CHAN_W-1:0]    rsp_green_out,
   input  wire logic [gfb_pkg::CHAN_W-1:0]    rsp_red_out,
   output int                                 fail_count,
   output int                                 pending_words
);
   import gfb_pkg::*;

   logic [PHASE_W-1:0] frame_phase_q;
   logic               primed;
   logic [SLOT_W-1:0]  capture_sel;
   logic               prime_frame;
   pixel_type          ghost_one [int];
   pixel_type          ghost_two [int];
   pixel_type          ghost_three [int];
   pixel_type          blended_words [$];
   int                 mismatches = 0;

   function automatic logic [CHAN_W-1:0] ghost_mix(input logic [CHAN_W-1:0] cur,
                                                   input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b,
                                                   input logic [CHAN_W-1:0] c);
      logic [CHAN_W+3:0] total;
      logic [CHAN_W-1:0] whole;
      logic              up;
      total = (12'(cur) * 12'd9) + 12'(a) + (12'(b) << 1) + (12'(c) << 2);
      whole = total[CHAN_W+3:4];
      up = (total[3:0] > 4'd8) || ((total[3:0] == 4'd8) && whole[0]);
      return whole + CHAN_W'(up);
   endfunction

   task automatic predict_word(input pixel_type cur, input logic [ADDR_IN_W-1:0] addr,
                               input logic start);
      logic      fill_all;
      int        key;
      pixel_type s1;
      pixel_type s2;
      pixel_type s3;
      pixel_type outw;
      key = int'(addr) % FRAME_PIXELS_DEFAULT;
      if (start) begin
         prime_frame = !primed;
         primed = 1'b1;
         case (frame_phase_q)
            PHASE_CAPTURE_ONE: capture_sel = SLOT_ONE;
            PHASE_CAPTURE_TWO: capture_sel = SLOT_TWO;
            PHASE_CAPTURE_THREE: capture_sel = SLOT_THREE;
            default: capture_sel = SLOT_NONE;
         endcase
         frame_phase_q = (frame_phase_q >= PHASE_LAST) ? '0 : frame_phase_q + 1'b1;
      end
      fill_all = prime_frame || !primed;
      if (fill_all || capture_sel == SLOT_ONE) begin
         ghost_one[key] = cur;
      end
      if (fill_all || capture_sel == SLOT_TWO) begin
         ghost_two[key] = cur;
      end
      if (fill_all || capture_sel == SLOT_THREE) begin
         ghost_three[key] = cur;
      end
      s1 = ghost_one.exists(key) ? ghost_one[key] : '0;
      s2 = ghost_two.exists(key) ? ghost_two[key] : '0;
      s3 = ghost_three.exists(key) ? ghost_three[key] : '0;
      outw.blue = ghost_mix(cur.blue, s1.blue, s2.blue, s3.blue);
      outw.green = ghost_mix(cur.green, s1.green, s2.green, s3.green);
      outw.red = ghost_mix(cur.red, s1.red, s2.red, s3.red);
      blended_words.push_back(outw);
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         frame_phase_q = '0;
         primed = 1'b0;
         capture_sel = SLOT_NONE;
         prime_frame = 1'b0;
         ghost_one.delete();
         ghost_two.delete();
         ghost_three.delete();
         blended_words.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (blended_words.size() == 0) begin
               $error("unexpected word: blue_out %0d green_out %0d red_out %0d",
                      rsp_blue_out, rsp_green_out, rsp_red_out);
               mismatches++;
            end else begin
               want = blended_words.pop_front();
               if (want.blue !== rsp_blue_out) begin
                  $error("blue_out expected %0d actual %0d", want.blue, rsp_blue_out);
                  mismatches++;
               end
               if (want.green !== rsp_green_out) begin
                  $error("green_out expected %0d actual %0d", want.green, rsp_green_out);
                  mismatches++;
               end
               if (want.red !== rsp_red_out) begin
                  $error("red_out expected %0d actual %0d", want.red, rsp_red_out);
                  mismatches++;
               end
            end
         end
         if (req_push && !req_full) begin
            predict_word({req_red_in, req_green_in, req_blue_in}, req_pixel_address,
                         req_frame_start);
         end
      end
      fail_count <= mismatches;
      pending_words <= blended_words.size();
   end

endmodule

### tb/ghost_frame_blend_unit_tb.sv
module ghost_frame_blend_unit_tb;
   import gfb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 700;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [CHAN_W-1:0]    req_blue_in = '0;
   logic [CHAN_W-1:0]    req_green_in = '0;
   logic [CHAN_W-1:0]    req_red_in = '0;
   logic [ADDR_IN_W-1:0] req_pixel_address = '0;
   logic                 req_frame_start = 1'b0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [CHAN_W-1:0]    rsp_blue_out;
   logic [CHAN_W-1:0]    rsp_green_out;
   logic [CHAN_W-1:0]    rsp_red_out;
   int                   fail_count;
   int                   pending_words;

   int                   tx_idle = 13;
   int                   rx_idle = 78;
   int                   words_sent = 0;
   int                   starts_sent = 0;
   logic [ADDR_IN_W-1:0] filled_pool [$];
   bit                   in_pool [int];

   ghost_frame_blend_unit dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_blue_in(req_blue_in),
      .req_green_in(req_green_in),
      .req_red_in(req_red_in),
      .req_pixel_address(req_pixel_address),
      .req_frame_start(req_frame_start),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_blue_out(rsp_blue_out),
      .rsp_green_out(rsp_green_out),
      .rsp_red_out(rsp_red_out)
   );

   ghost_frame_blend_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_blue_in(req_blue_in),
      .req_green_in(req_green_in),
      .req_red_in(req_red_in),
      .req_pixel_address(req_pixel_address),
      .req_frame_start(req_frame_start),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_blue_out(rsp_blue_out),
      .rsp_green_out(rsp_green_out),
      .rsp_red_out(rsp_red_out),
      .fail_count(fail_count),
      .pending_words(pending_words)
   );

   always #10 clock = ~clock;

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("ghost_frame_blend_unit regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= rx_idle);
   end

   function automatic logic [CHAN_W-1:0] pick_channel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   function automatic logic [ADDR_IN_W-1:0] pool_address(int index);
      return filled_pool[index % filled_pool.size()];
   endfunction

   // Once the first frame is over at most one store takes each pixel, so
   // addresses are drawn from those that all three stores already hold.
   task automatic send_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] r, input logic [ADDR_IN_W-1:0] addr,
                             input logic start);
      while ($urandom_range(99) < tx_idle) begin
         req_push <= 1'b0;
         req_blue_in <= CHAN_W'($urandom);
         req_pixel_address <= ADDR_IN_W'($urandom);
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_blue_in <= b;
      req_green_in <= g;
      req_red_in <= r;
      req_pixel_address <= addr;
      req_frame_start <= start;
      @(posedge clock);
      while (req_full) @(posedge clock);
      words_sent++;
      if (start) begin
         starts_sent++;
      end
      if (starts_sent <= 1 && !in_pool.exists(int'(addr))) begin
         in_pool[int'(addr)] = 1'b1;
         filled_pool.push_back(addr);
      end
   endtask

   task automatic send_frame();
      int base;
      int len;
      bit noisy;
      base = $urandom_range(filled_pool.size() - 1);
      len = $urandom_range(1, 20);
      noisy = ($urandom_range(9) < 2);
      for (int i = 0; i < len; i++) begin
         if (noisy) begin
            send_pixel(pick_channel(), pick_channel(), pick_channel(),
                       pool_address($urandom_range(filled_pool.size() - 1)),
                       ($urandom_range(3) == 0));
         end else begin
            send_pixel(pick_channel(), pick_channel(), pick_channel(),
                       pool_address(base + i), (i == 0));
         end
      end
   endtask

   initial begin
      int goal;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Before any frame start the output equals the input.
      send_pixel('0, '0, '0, '0, 1'b0);
      send_pixel('1, '1, '1, '1, 1'b0);
      send_pixel('0, '1, '0, 19'h2AAAA, 1'b0);
      send_pixel('1, '0, '1, 19'h55555, 1'b0);
      // The first frame fills all three stores.
      send_pixel('1, '0, '0, '0, 1'b1);
      send_pixel('0, '0, '1, '1, 1'b0);
      send_pixel(8'd128, 8'd127, 8'd1, 19'h2AAAA, 1'b0);
      for (int i = 0; i < 40; i++) begin
         send_pixel(pick_channel(), pick_channel(), pick_channel(), ADDR_IN_W'($urandom),
                    1'b0);
      end
      // Single-pixel frames walk the phase through every value and a wrap.
      for (int i = 0; i < 14; i++) begin
         send_pixel((i % 2) ? '1 : '0, (i % 3) ? '1 : '0, (i % 2) ? '0 : '1,
                    pool_address(i % 4), 1'b1);
      end

      goal = words_sent + PHASE_ITEMS;
      while (words_sent < goal) send_frame();

      tx_idle = 78;
      rx_idle = 13;
      goal = words_sent + PHASE_ITEMS;
      while (words_sent < goal) send_frame();

      tx_idle = 0;
      rx_idle = 0;
      goal = words_sent + PHASE_ITEMS;
      while (words_sent < goal) send_frame();

      req_push <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("ghost_frame_blend_unit regression: pass");
      end else begin
         $display("ghost_frame_blend_unit regression: fail");
      end
      $finish;
   end

endmodule
